### rtl/vfat_pkg.sv
`timescale 1ns / 1ps

package vfat_pkg;

  typedef enum logic [1:0] {
    CLOSE_NONE      = 2'd0,
    CLOSE_DELIVERED = 2'd1,
    CLOSE_DROPPED   = 2'd2,
    CLOSE_DISCARDED = 2'd3
  } close_status_e;

  localparam logic [7:0] FLAG_FORCE_DELIVER = 8'd1;

  localparam logic [7:0] CFG_ACK_FRAME_TYPE = 8'd0;
  localparam logic [7:0] CFG_ACK_CHANNEL    = 8'd1;

  // One acknowledgment as it leaves the block.
  typedef struct packed {
    logic [15:0]   ack_frame;
    logic [63:0]   ack_bits_low;
    logic [63:0]   ack_bits_high;
    logic [7:0]    sequence_res;
    close_status_e closed_status;
    logic [15:0]   closed_frame;
  } ack_t;

endpackage

### rtl/video_fragment_ack_tracker.sv
// Fragment acknowledgment tracker for the receive side of a fragmented video stream.
// Input channel: one fragment header per request (frame number, flags, fragment
// index, fragments per frame), accepted when in_valid_i is high and in_stall_o low.
// Output channel: one acknowledgment per request (current frame, 128-bit received
// bitmap in two halves, sequence number, and the status and number of any frame
// that the request closed), taken when out_valid_o is high and out_stall_i low.
// The acknowledgment is registered. Throughput is one request per cycle while in_stall_o
// is low; the frame state is updated in the accepting cycle by a compare, a bitmap
// clear-and-set and a completeness test over the bitmap.
// A two-entry output buffer (result register plus skid register) lets the block
// take one more request while the receiver stalls; in_stall_o rises only when both
// entries are full, so it is a registered signal.
// Reset clears the frame state, the bitmap and the sequence counter, and empties
// the output buffer. The configuration port holds the acknowledgment header bytes
// (frame type at index 0, channel at index 1); write it only while the block is idle.
`timescale 1ns / 1ps

module video_fragment_ack_tracker
  import vfat_pkg::*;
#(
  parameter int MAX_FRAGMENTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] frame_number_i,
  input  logic [7:0]  frame_flags_i,
  input  logic [6:0]  fragment_index_i,
  input  logic [7:0]  fragments_in_frame_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] ack_frame_o,
  output logic [63:0] ack_bits_low_o,
  output logic [63:0] ack_bits_high_o,
  output logic [7:0]  sequence_res_o,
  output logic [1:0]  closed_status_o,
  output logic [15:0] closed_frame_o
);

  localparam int         MaskW   = MAX_FRAGMENTS;
  localparam logic [7:0] MaxFrag = 8'(MAX_FRAGMENTS);

  // Acknowledgment header bytes.
  logic [7:0] ack_frame_type_q;
  logic [7:0] ack_channel_q;

  logic [15:0]      cur_frame_q,  cur_frame_d;
  logic [7:0]       cur_flags_q,  cur_flags_d;
  logic [7:0]       exp_count_q,  exp_count_d;
  logic             any_recv_q;
  logic [MaskW-1:0] mask_q,       mask_d;
  logic [7:0]       seq_q,        seq_d;

  logic             out_valid_q, skid_valid_q;
  ack_t             out_q, skid_q, res_d;

  logic             accept;
  logic             out_ready;
  logic             new_frame;
  logic             frame_done;
  logic [MaskW-1:0] need_mask;
  logic [MaskW-1:0] set_mask;
  logic [127:0]     bits_full;
  close_status_e    status_d;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  // Bit i of need_mask marks a fragment that the stored frame expects.
  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      need_mask[i] = (8'(i) < exp_count_q);
    end
  end

  // A frame expecting more fragments than can be marked is never complete.
  assign frame_done = (exp_count_q <= MaxFrag) && (&(mask_q | ~need_mask));
  assign new_frame  = (frame_number_i != cur_frame_q);

  always_comb begin
    status_d = CLOSE_NONE;
    if (new_frame && any_recv_q) begin
      if (cur_flags_q == FLAG_FORCE_DELIVER || frame_number_i > cur_frame_q) begin
        status_d = frame_done ? CLOSE_DELIVERED : CLOSE_DROPPED;
      end else begin
        status_d = CLOSE_DISCARDED;
      end
    end
  end

  always_comb begin
    set_mask = '0;
    if ({1'b0, fragment_index_i} < MaxFrag) begin
      set_mask = MaskW'(1) << fragment_index_i;
    end
    cur_frame_d = new_frame ? frame_number_i       : cur_frame_q;
    cur_flags_d = new_frame ? frame_flags_i        : cur_flags_q;
    exp_count_d = new_frame ? fragments_in_frame_i : exp_count_q;
    mask_d      = (new_frame ? '0 : mask_q) | set_mask;
    seq_d       = seq_q + 8'd1;

    bits_full            = '0;
    bits_full[MaskW-1:0] = mask_d;

    res_d.ack_frame     = cur_frame_d;
    res_d.ack_bits_low  = bits_full[63:0];
    res_d.ack_bits_high = bits_full[127:64];
    res_d.sequence_res  = seq_d;
    res_d.closed_status = status_d;
    res_d.closed_frame  = (status_d != CLOSE_NONE) ? cur_frame_q : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_frame_type_q <= '0;
      ack_channel_q    <= '0;
      cur_frame_q      <= '0;
      cur_flags_q      <= '0;
      exp_count_q      <= '0;
      any_recv_q       <= 1'b0;
      mask_q           <= '0;
      seq_q            <= '0;
      out_valid_q      <= 1'b0;
      skid_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_ACK_FRAME_TYPE) begin
        ack_frame_type_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_ACK_CHANNEL) begin
        ack_channel_q <= cfg_data_i;
      end
      if (accept) begin
        cur_frame_q <= cur_frame_d;
        cur_flags_q <= cur_flags_d;
        exp_count_q <= exp_count_d;
        any_recv_q  <= 1'b1;
        mask_q      <= mask_d;
        seq_q       <= seq_d;
      end
      if (out_ready) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ack_frame_o     = out_q.ack_frame;
  assign ack_bits_low_o  = out_q.ack_bits_low;
  assign ack_bits_high_o = out_q.ack_bits_high;
  assign sequence_res_o  = out_q.sequence_res;
  assign closed_status_o = out_q.closed_status;
  assign closed_frame_o  = out_q.closed_frame;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register is empty");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> seq_q == 8'($past(seq_q) + 8'd1))
    else $error("sequence number did not advance by one on a request");

  a_recv_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> any_recv_q && cur_frame_q == $past(frame_number_i))
    else $error("frame state not taken over after a request");

  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.closed_status == CLOSE_NONE) |-> out_q.closed_frame == 16'd0)
    else $error("closed frame number set without a closed frame");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_valid_q) |=> out_valid_q && !skid_valid_q)
    else $error("request into empty buffer did not land in result register");
`endif

endmodule

### verif/tb_video_fragment_ack_tracker.sv
`timescale 1ns / 1ps

module tb_video_fragment_ack_tracker;
  import vfat_pkg::*;

  localparam int MAX_FRAGS   = 128;
  localparam int IDLE_PCT    = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_index_i = CFG_ACK_FRAME_TYPE;
  logic [7:0]  cfg_data_i = 8'd0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] frame_number_i = 16'd0;
  logic [7:0]  frame_flags_i = 8'd0;
  logic [6:0]  fragment_index_i = 7'd0;
  logic [7:0]  fragments_in_frame_i = 8'd0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] ack_frame_o;
  logic [63:0] ack_bits_low_o;
  logic [63:0] ack_bits_high_o;
  logic [7:0]  sequence_res_o;
  logic [1:0]  closed_status_o;
  logic [15:0] closed_frame_o;

  video_fragment_ack_tracker #(
    .MAX_FRAGMENTS(MAX_FRAGS)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .frame_number_i      (frame_number_i),
    .frame_flags_i       (frame_flags_i),
    .fragment_index_i    (fragment_index_i),
    .fragments_in_frame_i(fragments_in_frame_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .ack_frame_o         (ack_frame_o),
    .ack_bits_low_o      (ack_bits_low_o),
    .ack_bits_high_o     (ack_bits_high_o),
    .sequence_res_o      (sequence_res_o),
    .closed_status_o     (closed_status_o),
    .closed_frame_o      (closed_frame_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Tracker state as the block should hold it.
  logic [15:0]  cur_frame = '0;
  logic [7:0]   cur_flags = '0;
  logic [7:0]   exp_count = '0;
  logic         any_rx = 1'b0;
  logic [127:0] rx_mask = '0;
  logic [7:0]   ack_seq = '0;
  logic [7:0]   hdr_frame_type = '0;
  logic [7:0]   hdr_channel = '0;

  // Newest prediction at the front, oldest at the back.
  ack_t ack_queue[$];

  int   errors = 0;
  int   items_sent = 0;
  int   acks_checked = 0;
  int   header_writes = 0;
  int   close_count[4] = '{0, 0, 0, 0};
  int   stuck_cycles = 0;
  bit   sender_quiet = 1'b0;
  bit   receiver_quiet = 1'b0;
  bit   hold_off_req = 1'b0;

  function automatic bit frame_is_complete();
    for (int i = 0; i < int'(exp_count); i++) begin
      if (i >= MAX_FRAGS) return 1'b0;
      if (!rx_mask[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ack_t predict_ack(input logic [15:0] num, input logic [7:0] flags,
                                       input logic [6:0] idx, input logic [7:0] count);
    ack_t a;
    a.closed_status = CLOSE_NONE;
    a.closed_frame  = '0;
    if (num != cur_frame) begin
      if (any_rx) begin
        a.closed_frame = cur_frame;
        if (cur_flags == FLAG_FORCE_DELIVER || num > cur_frame) begin
          a.closed_status = frame_is_complete() ? CLOSE_DELIVERED : CLOSE_DROPPED;
        end else begin
          a.closed_status = CLOSE_DISCARDED;
        end
      end
      cur_frame = num;
      cur_flags = flags;
      exp_count = count;
      any_rx    = 1'b0;
      rx_mask   = '0;
    end
    if (int'(idx) < MAX_FRAGS) rx_mask[idx] = 1'b1;
    any_rx  = 1'b1;
    ack_seq = ack_seq + 8'd1;
    a.ack_frame     = cur_frame;
    a.ack_bits_low  = rx_mask[63:0];
    a.ack_bits_high = rx_mask[127:64];
    a.sequence_res  = ack_seq;
    return a;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] ack %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, acks_checked, field, got, want);
    errors++;
  endtask

  // Compare every taken acknowledgment with the oldest prediction.
  always @(posedge clk_i) begin
    ack_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ack_queue.size() == 0) begin
        report_mismatch("unexpected ack, frame", {48'd0, ack_frame_o}, 64'd0);
      end else begin
        want = ack_queue.pop_back();
        if (ack_frame_o !== want.ack_frame)
          report_mismatch("ack_frame", {48'd0, ack_frame_o}, {48'd0, want.ack_frame});
        if (ack_bits_low_o !== want.ack_bits_low)
          report_mismatch("ack_bits_low", ack_bits_low_o, want.ack_bits_low);
        if (ack_bits_high_o !== want.ack_bits_high)
          report_mismatch("ack_bits_high", ack_bits_high_o, want.ack_bits_high);
        if (sequence_res_o !== want.sequence_res)
          report_mismatch("sequence_res", {56'd0, sequence_res_o}, {56'd0, want.sequence_res});
        if (closed_status_o !== want.closed_status)
          report_mismatch("closed_status", {62'd0, closed_status_o},
                          {62'd0, want.closed_status});
        if (closed_frame_o !== want.closed_frame)
          report_mismatch("closed_frame", {48'd0, closed_frame_o}, {48'd0, want.closed_frame});
        close_count[int'(want.closed_status)]++;
      end
      acks_checked++;
    end
  end

  // Receiver: random stalls, or one long counted hold-off when requested.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end
      out_stall_i <= receiver_quiet ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d acks pending",
               stuck_cycles, ack_queue.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge where the request was taken,
  // with valid still high so that the next request can follow back to back.
  task automatic send_fragment(input logic [15:0] num, input logic [7:0] flags,
                               input logic [6:0] idx, input logic [7:0] count);
    if (!sender_quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i           <= 1'b1;
    frame_number_i       <= num;
    frame_flags_i        <= flags;
    fragment_index_i     <= idx;
    fragments_in_frame_i <= count;
    do @(posedge clk_i); while (in_stall_o);
    ack_queue.push_front(predict_ack(num, flags, idx, count));
    items_sent++;
  endtask

  task automatic drain_acks();
    in_valid_i <= 1'b0;
    while (ack_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_ack_header(input logic [7:0] frame_type, input logic [7:0] channel);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ACK_FRAME_TYPE;
    cfg_data_i  <= frame_type;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACK_CHANNEL;
    cfg_data_i  <= channel;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_frame_type = frame_type;
    hdr_channel    = channel;
    header_writes++;
  endtask

  // Frames are sent as mostly well-formed fragment runs with random content,
  // mixed with skipped, repeated and stray fragments and fully random headers.
  task automatic run_frames(input int n_items);
    int          sent;
    int          roll;
    int          nfrag;
    int          j;
    int          tmp;
    int          order[MAX_FRAGS];
    logic [15:0] num;
    logic [7:0]  flags;
    logic [7:0]  count;
    sent = 0;
    num  = cur_frame;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) num = num + 16'($urandom_range(1, 3));
      else if (roll < 85) num = num - 16'($urandom_range(1, 4));
      else num = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 70) flags = 8'd0;
      else if (roll < 85) flags = FLAG_FORCE_DELIVER;
      else flags = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 4) count = 8'd128;
      else if (roll < 9) count = 8'd0;
      else if (roll < 12) count = 8'($urandom_range(129, 255));
      else count = 8'($urandom_range(1, 12));

      if (count == 8'd0 || count > 8'd128) begin
        nfrag = $urandom_range(1, 6);
        for (j = 0; j < nfrag; j++) order[j] = $urandom_range(0, MAX_FRAGS - 1);
      end else begin
        nfrag = int'(count);
        for (j = 0; j < nfrag; j++) order[j] = j;
        for (j = nfrag - 1; j > 0; j--) begin
          roll     = $urandom_range(0, j);
          tmp      = order[j];
          order[j] = order[roll];
          order[roll] = tmp;
        end
      end

      for (j = 0; j < nfrag && sent < n_items; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_fragment(16'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
          sent++;
          num = cur_frame;
        end
        if (roll < 8 && num != cur_frame) continue;
        if (roll >= 92) begin
          send_fragment(num, 8'($urandom), 7'($urandom), 8'($urandom));
          sent++;
        end else if (roll < 8 || roll >= 88) begin
          // A skipped fragment leaves the frame incomplete.
          if (roll >= 88) continue;
        end else begin
          send_fragment(num, 8'($urandom), 7'(order[j]), 8'($urandom));
          sent++;
          if (roll < 13 && sent < n_items) begin
            send_fragment(num, 8'($urandom), 7'(order[j]), 8'($urandom));
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_directed();
    // Frame 0 matches the reset frame, so its header fields are not taken over.
    send_fragment(16'h0000, 8'h00, 7'd0,   8'd3);
    send_fragment(16'h0000, 8'h00, 7'd1,   8'd3);
    // Frame 0 closes with zero expected fragments, which counts as complete.
    send_fragment(16'h0005, 8'h00, 7'd127, 8'd0);
    send_fragment(16'h0005, 8'h00, 7'd64,  8'd0);
    send_fragment(16'h0005, 8'h00, 7'd63,  8'd0);
    // Lower number without the force flag: out of order.
    send_fragment(16'h0003, 8'h01, 7'd0,   8'd3);
    send_fragment(16'h0003, 8'h00, 7'd2,   8'd3);
    // Forced close of an incomplete frame is still a drop.
    send_fragment(16'h0002, 8'h00, 7'd0,   8'd4);
    send_fragment(16'h0002, 8'h00, 7'd1,   8'd4);
    send_fragment(16'h0002, 8'h00, 7'd2,   8'd4);
    send_fragment(16'h0002, 8'h00, 7'd3,   8'd4);
    send_fragment(16'h0002, 8'h00, 7'd3,   8'd4);
    send_fragment(16'h0009, 8'hAA, 7'd100, 8'd255);
    send_fragment(16'h0009, 8'h55, 7'd127, 8'd0);
    // More fragments expected than can ever be marked.
    send_fragment(16'hFFFF, 8'h01, 7'd6,   8'd2);
    send_fragment(16'hFFFF, 8'hFF, 7'd0,   8'd2);
    send_fragment(16'hFFFF, 8'h00, 7'd1,   8'd2);
    // Forced delivery to a smaller number; the stray index 6 plays no part.
    send_fragment(16'h0000, 8'hFE, 7'd0,   8'd128);
    send_fragment(16'h8000, 8'h7F, 7'd127, 8'd128);
    send_fragment(16'h7FFF, 8'h80, 7'h55,  8'd1);
    send_fragment(16'h7FFF, 8'h00, 7'h2A,  8'd1);
    drain_acks();
  endtask

  task automatic test_random_traffic(input int n_items);
    run_frames(n_items);
    drain_acks();
  endtask

  task automatic test_quiet_stretch(input int n_items);
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    run_frames(n_items);
    drain_acks();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  task automatic test_backpressure(input int n_items);
    sender_quiet = 1'b1;
    hold_off_req = 1'b1;
    run_frames(n_items);
    drain_acks();
    sender_quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_ack_header(8'hFF, 8'h00);
    test_directed();
    set_ack_header(8'h00, 8'hFF);
    test_random_traffic(900);
    set_ack_header(8'($urandom), 8'($urandom));
    test_quiet_stretch(300);
    set_ack_header(8'hFF, 8'hFF);
    test_backpressure(60);
    set_ack_header(8'($urandom), 8'($urandom));
    test_random_traffic(700);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d fragment headers, checked %0d acks, %0d header settings (last %0h/%0h).",
             items_sent, acks_checked, header_writes, hdr_frame_type, hdr_channel);
    $display("Frames closed: %0d delivered, %0d dropped, %0d out of order; %0d mismatches.",
             close_count[CLOSE_DELIVERED], close_count[CLOSE_DROPPED],
             close_count[CLOSE_DISCARDED], errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/vfat_pkg.sv
rtl/video_fragment_ack_tracker.sv
verif/tb_video_fragment_ack_tracker.sv
